// ----- rtl/core/csc_pkg.sv -----
// Shared constants and elaboration-time table builders for the CORDIC
// sine/cosine core. Depends on nothing; every module of the core imports it.
`timescale 1ns / 1ps
`default_nettype none

package csc_pkg;

  // Default build parameters.
  localparam int MAX_ITERATIONS_DEF = 32;
  localparam int FRACTION_BITS_DEF  = 30;

  // Port widths fixed by the interface.
  localparam int ANGLE_W  = 32;
  localparam int OUT_W    = 32;
  localparam int OUT_FRAC = 30;
  localparam int CFG_W    = 6;

  // Iteration count after reset.
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(32);

  // Plus one in the output format.
  localparam logic [OUT_W-1:0] OUT_ONE = OUT_W'(64'd1 << OUT_FRAC);

  // Seed values at Q62.
  localparam logic [63:0] Q62_ONE         = 64'd1 << 62;
  localparam logic [63:0] Q62_PI_OVER_4   = 64'h3243F6A8885A308D;
  localparam logic [63:0] Q62_INV_SQRT2   = 64'h2D413CCCFE779921;

  // Restoring unsigned division, used only to build constant tables.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r    = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // (a * b) >> 62 with round to nearest, ties up.
  function automatic logic [63:0] mul_shift62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p + (128'd1 << 61);
    return p[125:62];
  endfunction

  // atan(2^-i) at Q62 by its power series.
  function automatic logic [63:0] atan_q62(input int i);
    logic [63:0] at;
    logic [63:0] term;
    int          e;
    if (i == 0) begin
      at = Q62_PI_OVER_4;
    end else begin
      at = '0;
      for (int j = 0; j < 64; j++) begin
        e = i * (2 * j + 1);
        if (e <= 62) begin
          term = udiv64(64'd1 << (62 - e), 64'(2 * j + 1));
          if ((j % 2) == 1) at = at - term;
          else              at = at + term;
        end
      end
    end
    return at;
  endfunction

  // 1/sqrt(1 + 4^-i) at Q62 by its binomial series.
  function automatic logic [63:0] inv_scale_q62(input int i);
    logic [63:0] r;
    logic [63:0] t;
    logic        done;
    if (i == 0) begin
      r = Q62_INV_SQRT2;
    end else begin
      r    = Q62_ONE;
      t    = Q62_ONE;
      done = 1'b0;
      if (2 * i < 63) begin
        for (int j = 1; j < 64; j++) begin
          if (!done) begin
            t = t >> (2 * i);
            t = t - udiv64(t, 64'(2 * j));
            if (t == 64'd0)      done = 1'b1;
            else if ((j % 2) == 1) r = r - t;
            else                 r = r + t;
          end
        end
      end
    end
    return r;
  endfunction

  // Product of inverse scale factors for steps zero through n, at Q62.
  function automatic logic [63:0] gain_q62(input int n);
    logic [63:0] k;
    k = Q62_ONE;
    for (int i = 0; i <= n; i++) begin
      k = mul_shift62(k, inv_scale_q62(i));
    end
    return k;
  endfunction

  // Round a Q62 value to fb fraction bits, ties up.
  function automatic logic [63:0] q62_to_frac(input logic [63:0] v, input int fb);
    return (v + (64'd1 << (62 - fb - 1))) >> (62 - fb);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/csc_cell.sv -----
// One micro-rotation cell of the CORDIC chain: a fixed shift and a fixed
// arctangent constant, registered outputs. Depends on csc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module csc_cell
  import csc_pkg::*;
#(
  parameter int              DW   = FRACTION_BITS_DEF + 3,
  parameter int              NW   = 6,
  parameter int              IDX  = 0,
  parameter logic [DW-1:0]   ATAN = '0
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 in_vld,
  input  wire logic [NW-1:0]        in_n,
  input  wire logic signed [DW-1:0] in_target,
  input  wire logic signed [DW-1:0] in_x,
  input  wire logic signed [DW-1:0] in_y,
  input  wire logic signed [DW-1:0] in_theta,
  output logic                      out_vld,
  output logic [NW-1:0]             out_n,
  output logic signed [DW-1:0]      out_target,
  output logic signed [DW-1:0]      out_x,
  output logic signed [DW-1:0]      out_y,
  output logic signed [DW-1:0]      out_theta
);

  logic                 vld_r;
  logic [NW-1:0]        n_r;
  logic signed [DW-1:0] target_r;
  logic signed [DW-1:0] x_r, x_nxt;
  logic signed [DW-1:0] y_r, y_nxt;
  logic signed [DW-1:0] theta_r, theta_nxt;
  logic signed [DW-1:0] xs, ys;
  logic                 active;

  // Rotate toward the target while this step is within the requested count.
  always_comb begin
    xs     = in_x >>> IDX;
    ys     = in_y >>> IDX;
    active = (in_n > NW'(IDX));
    x_nxt     = in_x;
    y_nxt     = in_y;
    theta_nxt = in_theta;
    if (active) begin
      if (in_theta < in_target) begin
        theta_nxt = in_theta + $signed(ATAN);
        x_nxt     = in_x - ys;
        y_nxt     = in_y + xs;
      end else begin
        theta_nxt = in_theta - $signed(ATAN);
        x_nxt     = in_x + ys;
        y_nxt     = in_y - xs;
      end
    end
  end

  // Valid bit of this cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  // Payload handed to the next cell.
  always_ff @(posedge clk) begin
    if (en) begin
      n_r      <= in_n;
      target_r <= in_target;
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      theta_r  <= theta_nxt;
    end
  end

  assign out_vld    = vld_r;
  assign out_n      = n_r;
  assign out_target = target_r;
  assign out_x      = x_r;
  assign out_y      = y_r;
  assign out_theta  = theta_r;

endmodule

`default_nettype wire

// ----- rtl/core/csc_scale.sv -----
// Gain correction for one coordinate: split multiply over registered partial
// products, rounding to Q1.30 and clamping to plus or minus one. Uses csc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module csc_scale
  import csc_pkg::*;
#(
  parameter int FB = FRACTION_BITS_DEF,
  parameter int DW = FRACTION_BITS_DEF + 3,
  parameter int GW = FRACTION_BITS_DEF + 1
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [DW-1:0] coord,
  input  wire logic [GW-1:0]        gain,
  output logic signed [OUT_W-1:0]   result
);

  localparam int H    = (DW + 1) / 2;
  localparam int PW   = 2 * H;
  localparam int FW   = 4 * H + 1;
  localparam int EXTW = DW + OUT_FRAC + 1;

  // Stage 1: sign and magnitude.
  logic          neg1_r;
  logic [DW-1:0] mag1_r, mag1_nxt;
  logic [GW-1:0] gain1_r;

  always_comb begin
    mag1_nxt = coord[DW-1] ? DW'(-coord) : DW'(coord);
  end

  // Stage 2: four partial products of half width.
  logic          neg2_r;
  logic [PW-1:0] pll_r, plh_r, phl_r, phh_r;
  logic [PW-1:0] mag_pad, gain_pad;
  logic [H-1:0]  ml, mh, gl, gh;

  always_comb begin
    mag_pad  = PW'(mag1_r);
    gain_pad = PW'(gain1_r);
    ml       = mag_pad[H-1:0];
    mh       = mag_pad[PW-1:H];
    gl       = gain_pad[H-1:0];
    gh       = gain_pad[PW-1:H];
  end

  // Stage 3: cross terms summed.
  logic          neg3_r;
  logic [PW:0]   mid3_r;
  logic [PW-1:0] ll3_r, hh3_r;

  // Stage 4: full product, rounded at the fraction point.
  logic          neg4_r;
  logic [DW-1:0] q4_r;
  logic [FW-1:0] full;

  always_comb begin
    full = FW'({hh3_r, ll3_r}) + (FW'(mid3_r) << H) + (FW'(1) << (FB - 1));
  end

  // Rescale to thirty fraction bits.
  logic [EXTW-1:0] sc;

  if (FB > OUT_FRAC) begin : g_down
    assign sc = (EXTW'(q4_r) + (EXTW'(1) << (FB - OUT_FRAC - 1))) >> (FB - OUT_FRAC);
  end else begin : g_up
    assign sc = EXTW'(q4_r) << (OUT_FRAC - FB);
  end

  // Stage 5: clamp and restore the sign.
  logic [OUT_W-1:0] clamped;
  logic [OUT_W-1:0] res_r, res_nxt;

  always_comb begin
    if (sc > EXTW'(OUT_ONE)) clamped = OUT_ONE;
    else                     clamped = sc[OUT_W-1:0];
    res_nxt = neg4_r ? (-clamped) : clamped;
  end

  // All payload stages advance together.
  always_ff @(posedge clk) begin
    if (en) begin
      neg1_r  <= coord[DW-1];
      mag1_r  <= mag1_nxt;
      gain1_r <= gain;
      neg2_r  <= neg1_r;
      pll_r   <= PW'(ml * gl);
      plh_r   <= PW'(ml * gh);
      phl_r   <= PW'(mh * gl);
      phh_r   <= PW'(mh * gh);
      neg3_r  <= neg2_r;
      mid3_r  <= (PW + 1)'(plh_r) + (PW + 1)'(phl_r);
      ll3_r   <= pll_r;
      hh3_r   <= phh_r;
      neg4_r  <= neg3_r;
      q4_r    <= full[FB +: DW];
      res_r   <= res_nxt;
    end
  end

  assign result = $signed(res_r);

endmodule

`default_nettype wire

// ----- rtl/core/cordic_sine_cosine_core.sv -----
// Top level of the CORDIC sine/cosine core: input register, chain of
// micro-rotation cells, gain correction. Uses csc_pkg, csc_cell, csc_scale.
//
//   channel  | ports                                   | direction
//   ---------+-----------------------------------------+----------
//   input    | in_valid, in_ready, in_angle            | in
//   result   | out_valid, out_ready, out_cosine_value, | out
//            | out_sine_value                          |
//   config   | cfg_valid, cfg_ready, cfg_iteration_count | in
//
// One request enters per cycle while the pipeline advances; a result passes the
// entry register, one cell per micro-rotation and the five-stage gain
// multiplier. Steps beyond the iteration count pass their cell unchanged.
// The whole pipeline holds while a finished result waits for out_ready.
// Reset is synchronous: it clears all valid bits and sets the count to 32.
`timescale 1ns / 1ps
`default_nettype none

module cordic_sine_cosine_core
  import csc_pkg::*;
#(
  parameter int MAX_ITERATIONS = MAX_ITERATIONS_DEF,
  parameter int FRACTION_BITS  = FRACTION_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic signed [ANGLE_W-1:0] in_angle,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [OUT_W-1:0]       out_cosine_value,
  output logic signed [OUT_W-1:0]       out_sine_value,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_W-1:0]         cfg_iteration_count
);

  localparam int DW    = FRACTION_BITS + 3;
  localparam int GW    = FRACTION_BITS + 1;
  localparam int NW    = $clog2(MAX_ITERATIONS + 1);
  localparam int GIW   = $clog2(MAX_ITERATIONS);
  localparam int EXTW  = ANGLE_W + FRACTION_BITS;
  localparam int SC_ST = 5;

  logic adv;

  // Configuration register.
  logic [CFG_W-1:0] iter_cnt_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iter_cnt_r <= CFG_RESET;
    end else if (cfg_valid) begin
      iter_cnt_r <= cfg_iteration_count;
    end
  end

  // The pipeline moves unless a finished result is still held.
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Entry stage: scaled target angle and saturated step count.
  logic                 ent_vld_r;
  logic [NW-1:0]        ent_n_r, ent_n_nxt;
  logic signed [DW-1:0] ent_target_r;
  logic signed [EXTW-1:0] ang_ext, ang_scaled;

  assign ang_ext = EXTW'(in_angle);

  if (FRACTION_BITS >= OUT_FRAC) begin : g_ang_up
    assign ang_scaled = ang_ext <<< (FRACTION_BITS - OUT_FRAC);
  end else begin : g_ang_down
    assign ang_scaled = ang_ext >>> (OUT_FRAC - FRACTION_BITS);
  end

  always_comb begin
    if (iter_cnt_r > CFG_W'(MAX_ITERATIONS)) ent_n_nxt = NW'(MAX_ITERATIONS);
    else                                     ent_n_nxt = NW'(iter_cnt_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= 1'b0;
    end else if (adv) begin
      ent_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ent_n_r      <= ent_n_nxt;
      ent_target_r <= ang_scaled[DW-1:0];
    end
  end

  // Chain of rotation cells; link zero starts from the unit vector.
  logic                 ch_vld    [MAX_ITERATIONS+1];
  logic [NW-1:0]        ch_n      [MAX_ITERATIONS+1];
  logic signed [DW-1:0] ch_target [MAX_ITERATIONS+1];
  logic signed [DW-1:0] ch_x      [MAX_ITERATIONS+1];
  logic signed [DW-1:0] ch_y      [MAX_ITERATIONS+1];
  logic signed [DW-1:0] ch_theta  [MAX_ITERATIONS+1];

  assign ch_vld[0]    = ent_vld_r;
  assign ch_n[0]      = ent_n_r;
  assign ch_target[0] = ent_target_r;
  assign ch_x[0]      = DW'(64'd1 << FRACTION_BITS);
  assign ch_y[0]      = '0;
  assign ch_theta[0]  = '0;

  for (genvar i = 0; i < MAX_ITERATIONS; i++) begin : g_cell
    localparam logic [63:0] ATAN_Q = q62_to_frac(atan_q62(i), FRACTION_BITS);

    csc_cell #(
      .DW   (DW),
      .NW   (NW),
      .IDX  (i),
      .ATAN (ATAN_Q[DW-1:0])
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (adv),
      .in_vld     (ch_vld[i]),
      .in_n       (ch_n[i]),
      .in_target  (ch_target[i]),
      .in_x       (ch_x[i]),
      .in_y       (ch_y[i]),
      .in_theta   (ch_theta[i]),
      .out_vld    (ch_vld[i+1]),
      .out_n      (ch_n[i+1]),
      .out_target (ch_target[i+1]),
      .out_x      (ch_x[i+1]),
      .out_y      (ch_y[i+1]),
      .out_theta  (ch_theta[i+1])
    );
  end

  // Gain table, one entry per nonzero iteration count.
  logic [GW-1:0] gain_tbl [MAX_ITERATIONS];

  for (genvar k = 0; k < MAX_ITERATIONS; k++) begin : g_gain
    localparam logic [63:0] GAIN_Q = q62_to_frac(gain_q62(k), FRACTION_BITS);
    assign gain_tbl[k] = GAIN_Q[GW-1:0];
  end

  logic [NW-1:0] gidx;
  logic [GW-1:0] gain_sel;

  always_comb begin
    gidx = ch_n[MAX_ITERATIONS] - NW'(1);
    if (ch_n[MAX_ITERATIONS] == '0) gain_sel = GW'(64'd1 << FRACTION_BITS);
    else                             gain_sel = gain_tbl[gidx[GIW-1:0]];
  end

  // Valid bits alongside the gain multiplier stages.
  logic [SC_ST-1:0] sc_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_vld_r <= '0;
    end else if (adv) begin
      sc_vld_r <= {sc_vld_r[SC_ST-2:0], ch_vld[MAX_ITERATIONS]};
    end
  end

  assign out_valid = sc_vld_r[SC_ST-1];

  // Gain correction of both coordinates.
  csc_scale #(
    .FB (FRACTION_BITS),
    .DW (DW),
    .GW (GW)
  ) u_scale_cos (
    .clk    (clk),
    .en     (adv),
    .coord  (ch_x[MAX_ITERATIONS]),
    .gain   (gain_sel),
    .result (out_cosine_value)
  );

  csc_scale #(
    .FB (FRACTION_BITS),
    .DW (DW),
    .GW (GW)
  ) u_scale_sin (
    .clk    (clk),
    .en     (adv),
    .coord  (ch_y[MAX_ITERATIONS]),
    .gain   (gain_sel),
    .result (out_sine_value)
  );

endmodule

`default_nettype wire

// ----- sim/cordic_sine_cosine_core_test.sv -----
// Self-checking testbench for the CORDIC sine/cosine core: drives angle requests
// and iteration counts, predicts each cosine/sine pair and checks every result.
// Depends on csc_pkg and cordic_sine_cosine_core from the RTL.
`timescale 1ns / 1ps

module cordic_sine_cosine_core_test;
  import csc_pkg::*;

  // Datapath format of the default build and the timing of the pipeline.
  localparam int FRAC         = 30;
  localparam int PIPE_LATENCY = MAX_ITERATIONS_DEF + 6;
  localparam int CYCLE_LIMIT  = 200000;

  // Angles in Q2.30 and the Q62 seeds of the rotation tables.
  localparam int          HALF_PI      = 1686629713;
  localparam int          QUARTER_PI   = 843314857;
  localparam int unsigned HALF_PI_SPAN = 32'd3373259426;
  localparam logic [63:0] PI_QUARTER_Q62 = 64'h3243F6A8885A308D;
  localparam logic [63:0] INV_ROOT2_Q62  = 64'h2D413CCCFE779921;
  localparam logic [63:0] UNIT_Q30       = 64'd1 << FRAC;

  typedef struct packed {
    logic signed [OUT_W-1:0] cosine;
    logic signed [OUT_W-1:0] sine;
  } trig_pair_t;

  logic                      clk;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [ANGLE_W-1:0] in_angle = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [OUT_W-1:0]   out_cosine_value;
  logic signed [OUT_W-1:0]   out_sine_value;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_W-1:0]          cfg_iteration_count = '0;

  // Predictor state: rotation tables and the iteration count last written.
  logic signed [63:0] atan_table [MAX_ITERATIONS_DEF];
  logic signed [63:0] gain_table [MAX_ITERATIONS_DEF];
  logic [CFG_W-1:0]   iteration_setting = CFG_RESET;

  trig_pair_t  expected_pairs[$];
  int          fault_count = 0;
  int          cycle_count = 0;
  logic        no_idle = 1'b0;

  cordic_sine_cosine_core i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_angle            (in_angle),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_cosine_value    (out_cosine_value),
    .out_sine_value      (out_sine_value),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_iteration_count (cfg_iteration_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run guard: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // The result side stalls at random, seven times in a hundred, unless no_idle is set.
  always @(posedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= 7);
  end

  // (a * b) >> s with round to nearest, ties up.
  function automatic logic [63:0] round_mul_shift(input logic [63:0] a, input logic [63:0] b,
                                                  input int s);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b} + (128'd1 << (s - 1));
    p = p >> s;
    return p[63:0];
  endfunction

  // Arctangent steps and cumulative gains, worked out at Q62 and rounded to Q30.
  function automatic void build_rotation_tables();
    logic [63:0] k;
    logic [63:0] at;
    logic [63:0] r;
    logic [63:0] t;
    logic [63:0] term;
    int          e;
    k = 64'd1 << 62;
    for (int i = 0; i < MAX_ITERATIONS_DEF; i++) begin
      if (i == 0) begin
        at = PI_QUARTER_Q62;
        r  = INV_ROOT2_Q62;
      end else begin
        // Power series of atan(2^-i).
        at = '0;
        for (int j = 0; j < 64; j++) begin
          e = i * (2 * j + 1);
          if (e > 62) break;
          term = (64'd1 << (62 - e)) / 64'(2 * j + 1);
          if (j % 2 == 1) at = at - term;
          else at = at + term;
        end
        // Binomial series of 1/sqrt(1 + 4^-i).
        r = 64'd1 << 62;
        if (2 * i < 63) begin
          t = 64'd1 << 62;
          for (int j = 1; j < 64; j++) begin
            t = t >> (2 * i);
            t = t - t / 64'(2 * j);
            if (t == 64'd0) break;
            if (j % 2 == 1) r = r - t;
            else r = r + t;
          end
        end
      end
      k = round_mul_shift(k, r, 62);
      atan_table[i] = (at + (64'd1 << (61 - FRAC))) >> (62 - FRAC);
      gain_table[i] = (k + (64'd1 << (61 - FRAC))) >> (62 - FRAC);
    end
  endfunction

  // Gain correction and conversion to Q1.30 on the magnitude, clamped to one.
  function automatic logic signed [OUT_W-1:0] scale_to_q30(input logic signed [63:0] v,
                                                           input logic [63:0] gain);
    logic        neg;
    logic [63:0] mag;
    neg = v[63];
    mag = neg ? -v : v;
    mag = round_mul_shift(mag, gain, FRAC);
    if (mag > UNIT_Q30) mag = UNIT_Q30;
    return neg ? OUT_W'(-mag) : OUT_W'(mag);
  endfunction

  // Rotation-mode CORDIC from (1, 0) toward the requested angle.
  function automatic trig_pair_t predict_sin_cos(input logic signed [ANGLE_W-1:0] angle);
    logic signed [63:0] target;
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] theta;
    logic signed [63:0] xs;
    logic signed [63:0] ys;
    logic [63:0]        gain;
    int                 steps;
    trig_pair_t         pair;
    target = {{(64 - ANGLE_W){angle[ANGLE_W-1]}}, angle};
    steps  = (iteration_setting > MAX_ITERATIONS_DEF) ? MAX_ITERATIONS_DEF
                                                      : int'(iteration_setting);
    x = 64'sd1 <<< FRAC;
    y = '0;
    theta = '0;
    for (int i = 0; i < steps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (theta < target) begin
        theta = theta + atan_table[i];
        x = x - ys;
        y = y + xs;
      end else begin
        theta = theta - atan_table[i];
        x = x + ys;
        y = y - xs;
      end
    end
    gain = (steps == 0) ? UNIT_Q30 : gain_table[steps-1];
    pair.cosine = scale_to_q30(x, gain);
    pair.sine   = scale_to_q30(y, gain);
    return pair;
  endfunction

  // Mostly angles within plus or minus pi/2, some over the full word, some tiny.
  function automatic logic signed [ANGLE_W-1:0] pick_angle();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 80)
      return ANGLE_W'(longint'($urandom_range(HALF_PI_SPAN)) - longint'(HALF_PI));
    else if (roll < 92)
      return ANGLE_W'($urandom);
    return ANGLE_W'(int'($urandom_range(2047)) - 1024);
  endfunction

  // Send one angle request; valid stays high until it is taken.
  task automatic send_angle(input logic signed [ANGLE_W-1:0] angle);
    int gap;
    gap = 0;
    if (!no_idle && $urandom_range(99) < 7) gap = 1;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_angle <= angle;
    do @(posedge clk); while (!in_ready);
    expected_pairs.push_back(predict_sin_cos(angle));
  endtask

  // Stop sending and wait until every result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  // Write the iteration count once the pipeline is empty.
  task automatic write_iterations(input logic [CFG_W-1:0] count);
    drain_results();
    cfg_valid           <= 1'b1;
    cfg_iteration_count <= count;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    iteration_setting = count;
  endtask

  // Compare each result with the oldest pending prediction.
  always @(posedge clk) begin : check_results
    trig_pair_t pair;
    if (rst_n && out_valid && out_ready) begin
      if (expected_pairs.size() == 0) begin
        $error("result with no request pending: cosine_value %0d sine_value %0d",
               out_cosine_value, out_sine_value);
        fault_count++;
      end else begin
        pair = expected_pairs.pop_front();
        if (out_cosine_value !== pair.cosine) begin
          $error("cosine_value: expected %0d, actual %0d", pair.cosine, out_cosine_value);
          fault_count++;
        end
        if (out_sine_value !== pair.sine) begin
          $error("sine_value: expected %0d, actual %0d", pair.sine, out_sine_value);
          fault_count++;
        end
      end
    end
  end

  // Extreme and landmark angles at the count left by reset.
  task automatic test_angle_extremes();
    send_angle(0);
    send_angle(1);
    send_angle(-1);
    send_angle(HALF_PI);
    send_angle(-HALF_PI);
    send_angle(QUARTER_PI);
    send_angle(-QUARTER_PI);
    send_angle(32'sh4000_0000);
    send_angle(-32'sh4000_0000);
    // Angles beyond pi/2 run the rotations as they are and clamp.
    send_angle(32'sh7FFF_FFFF);
    send_angle(32'sh8000_0000);
  endtask

  // Fewest steps, no steps at all, and counts above the table depth.
  task automatic test_iteration_extremes();
    write_iterations(CFG_W'(1));
    send_angle(0);
    send_angle(HALF_PI);
    send_angle(-HALF_PI);
    write_iterations(CFG_W'(0));
    send_angle(0);
    send_angle(QUARTER_PI);
    write_iterations(CFG_W'(63));
    send_angle(HALF_PI);
    send_angle(-QUARTER_PI);
    write_iterations(CFG_W'(33));
    send_angle(-HALF_PI);
    write_iterations(CFG_W'(MAX_ITERATIONS_DEF));
    send_angle(QUARTER_PI);
  endtask

  // Random angles over a run of counts, the extremes among them.
  task automatic test_random_sweep();
    logic [CFG_W-1:0] counts [9];
    counts = '{6'd32, 6'd1, 6'd0, 6'd63, 6'd33, 6'd8, 6'd16, 6'd31, 6'd2};
    for (int p = 0; p < 9; p++) begin
      if (p >= 7) counts[p] = CFG_W'($urandom_range(63));
      write_iterations(counts[p]);
      repeat (160) send_angle(pick_angle());
    end
  endtask

  // A long stretch with both sides always ready.
  task automatic test_unbroken_stream();
    write_iterations(CFG_W'(MAX_ITERATIONS_DEF));
    no_idle = 1'b1;
    repeat (400) send_angle(pick_angle());
    drain_results();
    no_idle = 1'b0;
  endtask

  initial begin
    build_rotation_tables();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_angle_extremes();
    test_iteration_extremes();
    test_random_sweep();
    test_unbroken_stream();
    drain_results();
    repeat (8) @(posedge clk);
    if (fault_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
